/* design/utf8_to_utf16_validating_decoder_assert.svh */
// ----------------------------------------------------------------------------
// utf8 to utf16 decoder assertion macros
// shared property macros for the decoder's concurrent checks
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_VALIDATING_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_VALIDATING_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define U8U16_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8u16 same-cycle check failed");

// next-cycle implication, checked out of reset
`define U8U16_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8u16 next-cycle check failed");

`endif

/* design/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16 package
// shared types and constants of the utf8 to utf16 decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
  localparam logic [20:0] SURR_LOW    = 21'h00D800;
  localparam logic [20:0] SURR_HIGH   = 21'h00DFFF;
  localparam logic [15:0] LEAD_BASE   = 16'hD800;
  localparam logic [15:0] TRAIL_BASE  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [20:0] MIN_LEN2    = 21'h000080;
  localparam logic [20:0] MIN_LEN3    = 21'h000800;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // sequence in progress
  typedef struct packed {
    logic [2:0]  seq_len;  // expected length, 0 when idle
    logic [1:0]  taken;    // bytes buffered, lead included
    logic [14:0] partial;  // point bits gathered so far
  } seq_state_t;

  // everything one request produces: a run of replacements, then up to two units
  typedef struct packed {
    logic [2:0]  n_units;
    logic [2:0]  n_repl;
    logic [15:0] tail0;
    logic        tail0_repl;
    logic [15:0] tail1;
    logic        eos;
  } unit_desc_t;

endpackage

/* design/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16 decode
// one byte against the sequence state: unit descriptor and next state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_decode (
  input  logic [7:0]             data_byte,
  input  logic                   eos,
  input  u8u16_pkg::seq_state_t  st,
  output u8u16_pkg::seq_state_t  st_nxt,
  output u8u16_pkg::unit_desc_t  desc
);

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic        repl;
    logic [2:0]  len;
    logic [14:0] bits;
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b, input logic end_flag);
    lead_t r;
    r = '0;
    if (b[7] == 1'b0) begin
      r.emit = 1'b1;
      r.unit = {8'h00, b};
    end else begin
      if (b[7:5] == 3'b110) begin
        r.len  = u8u16_pkg::LEN_TWO;
        r.bits = {10'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        r.len  = u8u16_pkg::LEN_THREE;
        r.bits = {11'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        r.len  = u8u16_pkg::LEN_FOUR;
        r.bits = {12'd0, b[2:0]};
      end
      if (r.len == u8u16_pkg::LEN_NONE || end_flag) begin
        r.emit = 1'b1;
        r.unit = u8u16_pkg::REPLACEMENT;
        r.repl = 1'b1;
        r.len  = u8u16_pkg::LEN_NONE;
        r.bits = '0;
      end
    end
    return r;
  endfunction

  lead_t       lead;
  logic        active;
  logic        is_cont;
  logic [20:0] cp;
  logic [2:0]  taken3;
  logic [20:0] minimum;
  logic        bad_point;
  logic [19:0] v;

  always_comb begin
    lead      = lead_decode(data_byte, eos);
    active    = (st.seq_len == u8u16_pkg::LEN_TWO || st.seq_len == u8u16_pkg::LEN_THREE ||
                 st.seq_len == u8u16_pkg::LEN_FOUR) && (st.taken != 2'd0);
    is_cont   = (data_byte[7:6] == 2'b10);
    cp        = {st.partial, data_byte[5:0]};
    taken3    = {1'b0, st.taken} + 3'd1;
    minimum   = (st.seq_len == u8u16_pkg::LEN_TWO)   ? u8u16_pkg::MIN_LEN2 :
                (st.seq_len == u8u16_pkg::LEN_THREE) ? u8u16_pkg::MIN_LEN3 :
                                                       u8u16_pkg::SUPP_BASE;
    bad_point = (cp < minimum) || (cp > u8u16_pkg::MAX_POINT) ||
                (cp >= u8u16_pkg::SURR_LOW && cp <= u8u16_pkg::SURR_HIGH);
    v         = 20'(cp - u8u16_pkg::SUPP_BASE);

    desc       = '0;
    desc.eos   = eos;
    st_nxt     = '0;

    if (!active) begin
      desc.n_units    = {2'd0, lead.emit};
      desc.tail0      = lead.unit;
      desc.tail0_repl = lead.repl;
      st_nxt.seq_len  = lead.len;
      st_nxt.taken    = (lead.len != u8u16_pkg::LEN_NONE) ? 2'd1 : 2'd0;
      st_nxt.partial  = lead.bits;
    end else if (is_cont) begin
      if (taken3 >= st.seq_len) begin
        if (bad_point) begin
          desc.n_repl  = st.seq_len;
          desc.n_units = st.seq_len;
        end else if (cp < u8u16_pkg::SUPP_BASE) begin
          desc.n_units = 3'd1;
          desc.tail0   = cp[15:0];
        end else begin
          // surrogate pair
          desc.n_units = 3'd2;
          desc.tail0   = u8u16_pkg::LEAD_BASE + {6'd0, v[19:10]};
          desc.tail1   = u8u16_pkg::TRAIL_BASE + {6'd0, v[9:0]};
        end
      end else if (eos) begin
        // truncated at end of string
        desc.n_repl  = taken3;
        desc.n_units = taken3;
      end else begin
        st_nxt.seq_len = st.seq_len;
        st_nxt.taken   = taken3[1:0];
        st_nxt.partial = cp[14:0];
      end
    end else begin
      // broken sequence: flush buffered bytes, then retry the byte as a lead
      desc.n_repl     = {1'b0, st.taken};
      desc.n_units    = {1'b0, st.taken} + {2'd0, lead.emit};
      desc.tail0      = lead.unit;
      desc.tail0_repl = lead.repl;
      st_nxt.seq_len  = lead.len;
      st_nxt.taken    = (lead.len != u8u16_pkg::LEN_NONE) ? 2'd1 : 2'd0;
      st_nxt.partial  = lead.bits;
    end

    if (eos) begin
      st_nxt = '0;
    end
  end

endmodule

/* design/utf8_to_utf16_validating_decoder.sv */
// ----------------------------------------------------------------------------
// utf8 to utf16 validating decoder
// streams utf8 bytes in, utf16 code units out, with u+fffd replacement
// ----------------------------------------------------------------------------
//
//   channel | handshake            | fields                                     | dir
//   --------+----------------------+--------------------------------------------+----
//   input   | in_valid, in_ready   | in_data_byte, in_end_of_string             | in
//   result  | out_valid, out_ready | out_code_unit, out_replaced, out_last_unit | out
//
// one byte request is taken per cycle while in_ready is high; it lands in the
// input register and is decoded from there into a descriptor held in the output slot
// a byte yields 0 to 4 units; the output slot sends one unit per cycle while
// out_ready is high, so a byte with several units holds the input side back
// while the slot drains, once both stages are full (the slot's unit counter sets this)
// bytes that yield no unit pass the decode stage without using the slot
// synchronous active-low reset clears the sequence state and both valid flags
`timescale 1ns / 1ps

module utf8_to_utf16_validating_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_replaced,
  output logic        out_last_unit
);

  `include "utf8_to_utf16_validating_decoder_assert.svh"

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eos_r;

  // sequence state, updated as the input register is decoded
  u8u16_pkg::seq_state_t st_r, st_nxt, st_dec;

  // output slot
  u8u16_pkg::unit_desc_t slot_r, slot_nxt, desc;
  logic                  slot_valid_r, slot_valid_nxt;
  logic [1:0]            idx_r, idx_nxt;

  logic in_acc;
  logic out_acc;
  logic slot_last;
  logic slot_done;
  logic s1_adv;
  logic [2:0] idx3;

  u8u16_decode u_decode (
    .data_byte (s1_byte_r),
    .eos       (s1_eos_r),
    .st        (st_r),
    .st_nxt    (st_dec),
    .desc      (desc)
  );

  always_comb begin
    idx3      = {1'b0, idx_r};
    slot_last = (idx3 == (slot_r.n_units - 3'd1));
    out_acc   = slot_valid_r && out_ready;
    slot_done = out_acc && slot_last;
    // decode stage moves on when its units have somewhere to go
    s1_adv    = s1_valid_r && ((desc.n_units == 3'd0) || !slot_valid_r || slot_done);
    in_ready  = !s1_valid_r || s1_adv;
    in_acc    = in_valid && in_ready;

    s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    st_nxt       = s1_adv ? st_dec : st_r;

    slot_nxt       = slot_r;
    slot_valid_nxt = slot_valid_r;
    idx_nxt        = idx_r;
    if (s1_adv && desc.n_units != 3'd0) begin
      slot_nxt       = desc;
      slot_valid_nxt = 1'b1;
      idx_nxt        = 2'd0;
    end else if (slot_done) begin
      slot_valid_nxt = 1'b0;
    end else if (out_acc) begin
      idx_nxt = idx_r + 2'd1;
    end

    // replacements first, then the decoded tail
    out_valid = slot_valid_r;
    if (idx3 < slot_r.n_repl) begin
      out_code_unit = u8u16_pkg::REPLACEMENT;
      out_replaced  = 1'b1;
    end else if (idx3 == slot_r.n_repl) begin
      out_code_unit = slot_r.tail0;
      out_replaced  = slot_r.tail0_repl;
    end else begin
      out_code_unit = slot_r.tail1;
      out_replaced  = 1'b0;
    end
    out_last_unit = slot_r.eos && slot_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      slot_valid_r <= 1'b0;
      st_r         <= '0;
      idx_r        <= 2'd0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      slot_valid_r <= slot_valid_nxt;
      st_r         <= st_nxt;
      idx_r        <= idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_data_byte;
      s1_eos_r  <= in_end_of_string;
    end
    slot_r <= slot_nxt;
  end

  // a held descriptor always has one to four units and a counter inside them
  `U8U16_ASSERT_IMP(a_slot_count, slot_valid_r,
    (slot_r.n_units != 3'd0) && (slot_r.n_units <= 3'd4) && (idx3 < slot_r.n_units))
  // a replaced unit is always u+fffd
  `U8U16_ASSERT_IMP(a_repl_value, out_valid && out_replaced,
    out_code_unit == u8u16_pkg::REPLACEMENT)
  // end of string leaves no sequence behind
  `U8U16_ASSERT_NXT(a_eos_clears, s1_adv && s1_eos_r, st_r.seq_len == u8u16_pkg::LEN_NONE)
  // a sequence in progress has buffered at least the lead and is not complete
  `U8U16_ASSERT_IMP(a_seq_sane, st_r.seq_len != u8u16_pkg::LEN_NONE,
    (st_r.taken != 2'd0) && ({1'b0, st_r.taken} < st_r.seq_len))
  // an end-of-string byte always produces a unit
  `U8U16_ASSERT_IMP(a_eos_emits, s1_valid_r && s1_eos_r, desc.n_units != 3'd0)

endmodule
